### design/lwlm_pkg.sv
package lwlm_pkg;

	localparam int DIVD_W = 32;
	localparam int DIVS_W = 17;
	localparam int METRIC_W = 9;
	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] STAT_UPDATED   = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_IDLE      = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_SMALL_WIN = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FLUSHED   = 3'd4;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	localparam logic REG_FLUSH_REWIND = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DECAY,
		ST_DECAY_WAIT,
		ST_ADD,
		ST_ADD_WAIT,
		ST_SHOW,
		ST_SHOW_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

### design/lwlm_ram.sv
module lwlm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/lwlm_div.sv
module lwlm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lwlm_pkg::div_req_t req,
	output lwlm_pkg::div_rsp_t rsp
);
	import lwlm_pkg::*;

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W:0]   rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVS_W+1:0] trial;
	logic [DIVS_W:0]   shifted;

	always_comb begin
		shifted = {rem_q[DIVS_W-1:0], quo_q[DIVD_W-1]};
		trial = {1'b0, shifted} - {2'b00, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[DIVS_W+1]) begin
				rem_q <= trial[DIVS_W:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

### design/lounged_window_link_metric.sv
// A flush, an out-of-range record, a small window or an update with nothing to do goes from
// read and evaluate straight to the result; other updates run decay steps on the shared
// serial divider (at most window_size-1 steps, stopping once the average is zero), divide
// once more to add a new probe and scale the shown metric. A stalled result holds the block;
// one transaction at a time, the next accepted in the cycle after the result is registered.
// Asynchronous active-low reset clears control state and marks all records as zero.
module lounged_window_link_metric #(
	parameter int NUM_RECORDS = 64,
	parameter int SEQ_BITS = 16,
	parameter int SCALE_FACTOR = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// record_index, probe, lag_allowance, seq_in, seq_max, window_size, zero fill
	input  logic [63:0] s_tdata,
	// command
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// metric_value, status, zero fill
	output logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lwlm_pkg::*;

	localparam int AW = NUM_RECORDS > 1 ? $clog2(NUM_RECORDS) : 1;
	localparam int RW = DIVD_W + METRIC_W + 2 * SEQ_BITS;
	localparam int SCALE_L = $clog2(SCALE_FACTOR);
	localparam int SHOW_N = METRIC_W + SCALE_L;
	localparam int SHOW_S = SHOW_N + SCALE_L;
	localparam int PROD_W = 2 * SHOW_N + 1;
	localparam longint SHOW_M = ((longint'(1) << SHOW_S) + longint'(SCALE_FACTOR) - 1)
		/ longint'(SCALE_FACTOR);
	localparam longint SHOW_LIM = longint'(SCALE_FACTOR) << METRIC_W;

	state_t state_q, state_d;

	logic [15:0]         rewind_q;
	logic [NUM_RECORDS-1:0] valid_q;
	logic                vld_s1;

	logic                cmd_q;
	logic [5:0]          idx_q;
	logic [7:0]          probe_q, lounge_q, ws_q;
	logic [SEQ_BITS-1:0] seqin_q, seqmax_q;

	logic [DIVD_W-1:0]   avg_q;
	logic [SEQ_BITS-1:0] clr_q, set_q;
	logic [METRIC_W-1:0] shown_q;
	logic [STATUS_W-1:0] status_q;
	logic                wr_q;
	logic [7:0]          cnt_q;
	logic [PROD_W-1:0]   prod_q;
	logic                sat_q;

	logic                out_valid_q;
	logic [15:0]         out_data_q;

	logic [AW-1:0]       addr;
	logic [RW-1:0]       rdata, wdata;
	logic [DIVD_W-1:0]   cur_avg;
	logic [METRIC_W-1:0] cur_shown;
	logic [SEQ_BITS-1:0] cur_clr, cur_set, target, offset, flush_clr;
	logic                oor, lag, big_skip;
	logic                out_free, accept, ram_we;
	logic [DIVS_W-1:0]   weight;
	logic [DIVD_W:0]     sum;
	div_req_t            dreq;
	div_rsp_t            drsp;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FLUSH_REWIND) ? {16'd0, rewind_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rewind_q <= 16'd255;
		end else if (psel && penable && pwrite && paddr[2] == REG_FLUSH_REWIND) begin
			rewind_q <= pwdata[15:0];
		end
	end

	assign addr = AW'(32'(idx_q));
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign ram_we = (state_q == ST_DONE) && out_free && wr_q;
	assign wdata = {set_q, clr_q, shown_q, avg_q};

	lwlm_ram #(.WIDTH(RW), .DEPTH(NUM_RECORDS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (wdata),
		.re    (state_q == ST_READ),
		.raddr (addr),
		.rdata (rdata)
	);

	lwlm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_comb begin
		cur_avg   = vld_s1 ? rdata[DIVD_W-1:0] : '0;
		cur_shown = vld_s1 ? rdata[DIVD_W +: METRIC_W] : '0;
		cur_clr   = vld_s1 ? rdata[DIVD_W+METRIC_W +: SEQ_BITS] : '0;
		cur_set   = vld_s1 ? rdata[DIVD_W+METRIC_W+SEQ_BITS +: SEQ_BITS] : '0;
		oor       = 32'(idx_q) >= 32'(NUM_RECORDS);
		lag       = (seqmax_q - cur_clr) > SEQ_BITS'(lounge_q);
		target    = (probe_q != 8'd0) ? seqin_q : seqmax_q - SEQ_BITS'(lounge_q);
		offset    = target - cur_clr;
		big_skip  = offset >= SEQ_BITS'(ws_q);
		flush_clr = cur_clr - SEQ_BITS'(32'(rewind_q));
		weight    = DIVS_W'(ws_q[7:1]);
		sum       = {1'b0, avg_q} + {1'b0, drsp.quotient};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dreq.start = 1'b0;
		dreq.dividend = avg_q;
		dreq.divisor = weight;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				if (oor || cmd_q == CMD_FLUSH || ws_q < 8'd2) begin
					state_d = ST_DONE;
				end else if (probe_q == 8'd0 && !lag) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_DECAY;
				end
			end
			ST_DECAY: begin
				if (cnt_q == 8'd0 || avg_q == '0) begin
					state_d = ST_ADD;
				end else begin
					dreq.start = 1'b1;
					state_d = ST_DECAY_WAIT;
				end
			end
			ST_DECAY_WAIT: begin
				if (drsp.done) begin
					state_d = ST_DECAY;
				end
			end
			ST_ADD: begin
				if (probe_q != 8'd0 && set_q != clr_q) begin
					dreq.start = 1'b1;
					dreq.dividend = 32'(probe_q) * 32'(SCALE_FACTOR);
					state_d = ST_ADD_WAIT;
				end else begin
					state_d = ST_SHOW;
				end
			end
			ST_ADD_WAIT: begin
				if (drsp.done) begin
					state_d = ST_SHOW;
				end
			end
			ST_SHOW: state_d = ST_SHOW_WAIT;
			ST_SHOW_WAIT: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= s_tuser[0];
			idx_q    <= s_tdata[5:0];
			probe_q  <= s_tdata[13:6];
			lounge_q <= s_tdata[21:14];
			seqin_q  <= SEQ_BITS'(32'(s_tdata[37:22]));
			seqmax_q <= SEQ_BITS'(32'(s_tdata[53:38]));
			ws_q     <= s_tdata[61:54];
		end
		unique case (state_q)
			ST_READ: vld_s1 <= valid_q[addr];
			ST_EVAL: begin
				if (oor) begin
					shown_q <= '0;
					set_q <= cur_set;
					wr_q <= 1'b0;
					status_q <= STAT_IDLE;
				end else if (cmd_q == CMD_FLUSH) begin
					avg_q <= '0;
					shown_q <= '0;
					clr_q <= flush_clr;
					set_q <= flush_clr;
					wr_q <= 1'b1;
					status_q <= STAT_FLUSHED;
				end else if (ws_q < 8'd2) begin
					shown_q <= cur_shown;
					set_q <= cur_set;
					wr_q <= 1'b0;
					status_q <= STAT_SMALL_WIN;
				end else if (probe_q == 8'd0 && !lag) begin
					shown_q <= cur_shown;
					set_q <= cur_set;
					wr_q <= 1'b0;
					status_q <= STAT_IDLE;
				end else begin
					shown_q <= cur_shown;
					set_q <= cur_set;
					wr_q <= 1'b0;
					avg_q <= big_skip ? '0 : cur_avg;
					cnt_q <= big_skip ? 8'd0 : offset[7:0];
					clr_q <= target;
					status_q <= STAT_UPDATED;
				end
			end
			ST_DECAY_WAIT: begin
				if (drsp.done) begin
					avg_q <= avg_q - drsp.quotient;
					cnt_q <= cnt_q - 8'd1;
				end
			end
			ST_ADD: begin
				if (probe_q != 8'd0 && set_q == clr_q) begin
					status_q <= STAT_DUPLICATE;
				end
			end
			ST_ADD_WAIT: begin
				if (drsp.done) begin
					avg_q <= sum[DIVD_W] ? '1 : sum[DIVD_W-1:0];
					set_q <= clr_q;
				end
			end
			ST_SHOW: begin
				prod_q <= PROD_W'(avg_q[SHOW_N-1:0]) * PROD_W'(SHOW_M);
				sat_q <= 64'(avg_q) >= 64'(SHOW_LIM);
			end
			ST_SHOW_WAIT: begin
				shown_q <= sat_q ? '1 : prod_q[SHOW_S +: METRIC_W];
				wr_q <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[addr] <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {4'd0, status_q, shown_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule

### design/lwlm_checker.sv
module lwlm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        pready
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11:9] <= 3'd4))
		else $error("Result status out of range.");

	a_flush_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[11:9] == 3'd4) |-> (m_tdata[8:0] == 9'd0))
		else $error("Flush result carries a nonzero metric.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("Input taken while a transaction is in progress.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("Stalled result changed.");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("Configuration port not ready.");

endmodule

bind lounged_window_link_metric lwlm_checker u_lwlm_checker (.*);
